@@ rtl/core/spq_pkg.sv @@
// Package for the sorted priority queue: shared types, codes and defaults.
// Used by spq_ctrl, spq_datapath and sorted_priority_queue_top.
// Depends on nothing.
`default_nettype none
package spq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int DATA_W          = 32;
  localparam int STATUS_W        = 2;
  localparam int COUNT_OUT_W     = 5;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_POP    = 1'b1
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  // What the datapath is to do with the item that is accepted this cycle.
  typedef enum logic [1:0] {
    ACT_INSERT    = 2'd0,
    ACT_POP       = 2'd1,
    ACT_DROP_FULL = 2'd2,
    ACT_POP_EMPTY = 2'd3
  } action_t;

  typedef struct packed {
    logic    exec;
    action_t act;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } dp_stat_t;

endpackage
`default_nettype wire

@@ rtl/core/spq_ctrl.sv @@
// Controller of the sorted priority queue: handshake state machine.
// Issues commands to spq_datapath from its status; uses spq_pkg.
`default_nettype none
module spq_ctrl (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_ready,
  input  wire              in_opcode,
  output logic             out_valid,
  input  wire              out_ready,
  input  spq_pkg::dp_stat_t dp_stat,
  output spq_pkg::dp_cmd_t  dp_cmd
);
  import spq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_HOLD = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  // A waiting result does not block the input: the next item may enter in
  // the cycle that the result is taken.
  assign in_ready  = (state_r == S_IDLE) || out_ready;
  assign out_valid = (state_r == S_HOLD);
  assign accept    = in_valid && in_ready;

  always_comb begin
    dp_cmd.exec = accept;
    if (in_opcode == OP_POP) begin
      dp_cmd.act = dp_stat.empty ? ACT_POP_EMPTY : ACT_POP;
    end else begin
      dp_cmd.act = dp_stat.full ? ACT_DROP_FULL : ACT_INSERT;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_HOLD;
      end
      S_HOLD: begin
        if (out_ready && !accept) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/spq_datapath.sv @@
// Datapath of the sorted priority queue: a chain of sorted entry cells,
// the fill count and the result registers. Driven by spq_ctrl; uses spq_pkg.
`default_nettype none
module spq_datapath #(
  parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  spq_pkg::dp_cmd_t                    dp_cmd,
  output spq_pkg::dp_stat_t                   dp_stat,
  input  wire signed [spq_pkg::DATA_W-1:0]    in_value,
  output logic signed [spq_pkg::DATA_W-1:0]   out_popped_value,
  output logic [spq_pkg::STATUS_W-1:0]        out_status,
  output logic                                out_now_empty,
  output logic [spq_pkg::COUNT_OUT_W-1:0]     out_entry_count
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic signed [DATA_W-1:0] entries_r [QUEUE_DEPTH];
  logic signed [DATA_W-1:0] entries_nxt [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]   below;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic signed [DATA_W-1:0] popped_r;
  status_t                  status_r;
  logic [CNT_W+COUNT_OUT_W-1:0] count_ext;

  assign dp_stat.full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign dp_stat.empty = (count_r == '0);

  // Each cell compares its own entry with the new value; the entries are
  // ascending, so the cells below the value form a prefix of the chain.
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      below[i] = (CNT_W'(i) < count_r) && (entries_r[i] < in_value);
    end
  end

  always_comb begin
    count_nxt = count_r;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      entries_nxt[i] = entries_r[i];
    end
    case (dp_cmd.act)
      ACT_INSERT: begin
        count_nxt = count_r + CNT_W'(1);
        if (!below[0]) begin
          entries_nxt[0] = in_value;
        end
        for (int i = 1; i < QUEUE_DEPTH; i++) begin
          if (!below[i]) begin
            if (below[i-1]) begin
              entries_nxt[i] = in_value;
            end else begin
              entries_nxt[i] = entries_r[i-1];
            end
          end
        end
      end
      ACT_POP: begin
        count_nxt = count_r - CNT_W'(1);
        for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
          entries_nxt[i] = entries_r[i+1];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.exec) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        entries_r[i] <= entries_nxt[i];
      end
      popped_r <= (dp_cmd.act == ACT_POP) ? entries_r[0] : '0;
      case (dp_cmd.act)
        ACT_DROP_FULL: status_r <= STAT_FULL;
        ACT_POP_EMPTY: status_r <= STAT_EMPTY;
        default:       status_r <= STAT_OK;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (dp_cmd.exec) begin
      count_r <= count_nxt;
    end
  end

  // The count only changes with a new result, so it can be shown directly.
  assign count_ext        = {{COUNT_OUT_W{1'b0}}, count_r};
  assign out_popped_value = popped_r;
  assign out_status       = status_r;
  assign out_now_empty    = (count_r == '0);
  assign out_entry_count  = count_ext[COUNT_OUT_W-1:0];

endmodule
`default_nettype wire

@@ rtl/core/sorted_priority_queue_top.sv @@
// Top level of the sorted priority queue: joins spq_ctrl and spq_datapath.
// Uses spq_pkg.
`default_nettype none
// A bounded ascending queue of signed 32-bit values held in a chain of
// QUEUE_DEPTH register cells. Each item is an insert (opcode 0), which places
// the value ahead of any equal entries, or a pop (opcode 1), which returns the
// smallest entry; every item gives exactly one result with the popped value,
// a status (ok, insert dropped because full, pop on empty), an empty flag and
// the entry count after the step. An item is executed in the cycle that it is
// accepted, since every cell makes its own compare and shift decision in
// parallel; its result appears in the next cycle from the result register,
// and a new item is accepted in the same cycle that a waiting result is taken,
// so the block sustains one item per cycle when the output is not stalled.
module sorted_priority_queue_top #(
  parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire                                 in_opcode,
  input  wire signed [spq_pkg::DATA_W-1:0]    in_value,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic signed [spq_pkg::DATA_W-1:0]   out_popped_value,
  output logic [spq_pkg::STATUS_W-1:0]        out_status,
  output logic                                out_now_empty,
  output logic [spq_pkg::COUNT_OUT_W-1:0]     out_entry_count
);
  import spq_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_opcode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dp_stat   (dp_stat),
    .dp_cmd    (dp_cmd)
  );

  spq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .dp_cmd           (dp_cmd),
    .dp_stat          (dp_stat),
    .in_value         (in_value),
    .out_popped_value (out_popped_value),
    .out_status       (out_status),
    .out_now_empty    (out_now_empty),
    .out_entry_count  (out_entry_count)
  );

endmodule
`default_nettype wire
